FILE: design/clmd_pkg.sv
// Package for the CBOR LwM2M map decoder: beat payloads, parse phases,
// event codes, CBOR header constants and key tables. No dependencies.
package clmd_pkg;

   // Result queue depth and its fill count width
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // CBOR header constants
   localparam logic [7:0] MAJOR_MASK  = 8'he0;
   localparam logic [7:0] INFO_MASK   = 8'h1f;
   localparam logic [7:0] MAJOR_UINT  = 8'h00;
   localparam logic [7:0] MAJOR_NINT  = 8'h20;
   localparam logic [7:0] MAJOR_BYTES = 8'h40;
   localparam logic [7:0] MAJOR_TEXT  = 8'h60;
   localparam logic [7:0] MAJOR_MAP   = 8'ha0;
   localparam logic [7:0] SIMPLE_TRUE = 8'hf5;
   localparam logic [4:0] AI_INLINE_MAX = 5'd23;
   localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
   localparam logic [4:0] AI_TWO_BYTE   = 5'd25;
   localparam logic [4:0] AI_FOUR_BYTE  = 5'd26;
   localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [15:0] msg_length;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [4:0]  field_key;
      logic [63:0] field_value;
      logic        end_of_field;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_MAP_ARG = 3'd1,
      PH_KEY_HDR = 3'd2,
      PH_KEY_ARG = 3'd3,
      PH_VAL_HDR = 3'd4,
      PH_VAL_ARG = 3'd5,
      PH_STR     = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_NUM   = 3'd0,
      EV_TEXT  = 3'd1,
      EV_OCTET = 3'd2,
      EV_EMPTY = 3'd3,
      EV_FLAG  = 3'd4,
      EV_OK    = 3'd5,
      EV_FAIL  = 3'd6
   } event_kind_type;

   typedef enum logic [2:0] {
      CL_NONE  = 3'd0,
      CL_NUM   = 3'd1,
      CL_TEXT  = 3'd2,
      CL_OCTET = 3'd3,
      CL_FLAG  = 3'd4
   } key_class_type;

   // Classify a full-width key value
   function automatic key_class_type key_class(input logic [63:0] k);
      key_class_type cls;
      cls = CL_NONE;
      if (k[63:5] == '0) begin
         unique case (k[4:0])
            5'd0, 5'd1, 5'd3, 5'd5, 5'd11, 5'd20, 5'd21: cls = CL_NUM;
            5'd2, 5'd6, 5'd10, 5'd12, 5'd13:             cls = CL_TEXT;
            5'd4:                                        cls = CL_OCTET;
            5'd14:                                       cls = CL_FLAG;
            default:                                     cls = CL_NONE;
         endcase
      end
      return cls;
   endfunction

   // Mask a numeric value to the width of its key's field
   function automatic logic [63:0] trunc_value(input logic [4:0] k, input logic [63:0] v);
      logic [63:0] r;
      unique case (k)
         5'd0, 5'd5:   r = {56'd0, v[7:0]};
         5'd3:         r = {48'd0, v[15:0]};
         5'd11, 5'd20: r = {32'd0, v[31:0]};
         default:      r = v;
      endcase
      return r;
   endfunction

   // Argument bytes that follow a header with this additional info
   function automatic logic [3:0] arg_need(input logic [4:0] ai);
      logic [3:0] n;
      unique case (ai)
         AI_ONE_BYTE:   n = 4'd1;
         AI_TWO_BYTE:   n = 4'd2;
         AI_FOUR_BYTE:  n = 4'd4;
         AI_EIGHT_BYTE: n = 4'd8;
         default:       n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: design/clmd_stream_if.sv
// Valid/ready channel interfaces for the decoder's byte input and event output.
// Depends on clmd_pkg for the payload types.
interface clmd_req_if;
   logic                      valid;
   logic                      ready;
   clmd_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface clmd_rsp_if;
   logic                      valid;
   logic                      ready;
   clmd_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/clmd_event_queue.sv
// Small shift queue of decoded events in front of the response channel.
// Takes up to two events per cycle; depends on clmd_pkg and clmd_rsp_if.
module clmd_event_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      push_count,
   input  clmd_pkg::rsp_payload_type [1:0] push_data,
   output logic                            has_room,
   clmd_rsp_if.source                      rsp_bus
);

   localparam int unsigned DEPTH = clmd_pkg::QUEUE_DEPTH;
   localparam int unsigned CNT_W = clmd_pkg::QCNT_BITS;

   clmd_pkg::rsp_payload_type slot_ff [DEPTH];
   clmd_pkg::rsp_payload_type slot_in [DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [CNT_W-1:0]          count_pop;
   logic                      pop;

   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign has_room = (count_ff <= CNT_W'(DEPTH - 2));

   assign rsp_bus.valid = (count_ff != '0);
   assign rsp_bus.data  = slot_ff[0];

   // Shift out the delivered beat, then append new events behind the backlog
   always_comb begin
      count_pop = count_ff - CNT_W'(pop);
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if ((push_count != 2'd0) && (CNT_W'(i) == count_pop)) begin
            slot_in[i] = push_data[0];
         end
         if ((push_count == 2'd2) && (CNT_W'(i) == count_pop + CNT_W'(1))) begin
            slot_in[i] = push_data[1];
         end
      end
      count_in = count_pop + CNT_W'(push_count);
   end

   // Hold the slots; they need no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/cbor_lwm2m_map_decoder.sv
// CBOR LwM2M map decoder: one message byte per input beat, field and status events out.
// Events: a byte's events are registered into the event queue, behind any backlog, when its beat is accepted.
// Throughput: one byte per cycle; a byte that ends a field and the map gives two events,
//   and the 4-entry event queue takes a byte only while two entries are free.
// Reset: synchronous, active high; clears the parse state to idle and empties the queue.
// Depends on clmd_pkg, clmd_stream_if and clmd_event_queue.
module cbor_lwm2m_map_decoder #(
   parameter int unsigned LEN_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   clmd_req_if.sink  req_bus,
   clmd_rsp_if.source rsp_bus
);

   // Parse state
   clmd_pkg::phase_type phase_ff, phase_in;
   logic [63:0]         entries_ff, entries_in;
   logic [LEN_BITS-1:0] bytes_ff, bytes_in;
   logic [3:0]          arg_left_ff, arg_left_in;
   logic [63:0]         accum_ff, accum_in;
   logic [4:0]          key_ff, key_in;
   logic                known_ff, known_in;
   logic [LEN_BITS-1:0] str_left_ff, str_left_in;
   logic                is_text_ff, is_text_in;

   // Step decode
   logic                      accept;
   logic [7:0]                cur_byte;
   logic [7:0]                major;
   logic [4:0]                info;
   logic [3:0]                need;
   logic [63:0]               hdr_val;
   logic [LEN_BITS-1:0]       msg_len;
   logic [LEN_BITS-1:0]       base_len;
   logic [LEN_BITS-1:0]       bl;
   logic                      hdr_go;
   logic [63:0]               shifted;
   logic [3:0]                arg_next;
   logic [LEN_BITS-1:0]       str_next;
   clmd_pkg::key_class_type   val_cls;
   logic                      do_key;
   logic [63:0]               key_val;
   logic                      key_known_arg;
   logic                      key_known;
   logic                      do_vdone;
   logic [63:0]               vd_val;
   logic                      do_finish;
   logic                      do_check;
   logic                      chk_empty;

   // Events
   logic                            field_valid;
   clmd_pkg::rsp_payload_type       field_ev;
   logic                            status_valid;
   clmd_pkg::event_kind_type        status_kind;
   clmd_pkg::rsp_payload_type       status_ev;
   logic [1:0]                      push_count;
   clmd_pkg::rsp_payload_type [1:0] push_data;
   logic                            has_room;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = has_room;

   // Header fields of the current byte
   assign cur_byte = req_bus.data.data_byte;
   assign major    = cur_byte & clmd_pkg::MAJOR_MASK;
   assign info     = 5'(cur_byte & clmd_pkg::INFO_MASK);
   assign need     = clmd_pkg::arg_need(info);
   assign hdr_val  = (info <= clmd_pkg::AI_INLINE_MAX) ? {59'd0, info} : 64'd0;
   assign msg_len  = LEN_BITS'(req_bus.data.msg_length);
   assign base_len = req_bus.data.first_byte ? msg_len : bytes_ff;
   assign bl       = base_len - LEN_BITS'(1);
   assign hdr_go   = (need != 4'd0) && (bl >= LEN_BITS'(need));
   assign shifted  = {accum_ff[55:0], cur_byte};
   assign arg_next = arg_left_ff - 4'(arg_left_ff != 4'd0);
   assign str_next = str_left_ff - LEN_BITS'(str_left_ff != '0);
   assign val_cls  = known_ff ? clmd_pkg::key_class({59'd0, key_ff}) : clmd_pkg::CL_NONE;

   // Next parse state and events for the accepted beat
   always_comb begin
      phase_in      = phase_ff;
      entries_in    = entries_ff;
      bytes_in      = bytes_ff;
      arg_left_in   = arg_left_ff;
      accum_in      = accum_ff;
      key_in        = key_ff;
      known_in      = known_ff;
      str_left_in   = str_left_ff;
      is_text_in    = is_text_ff;
      field_valid   = 1'b0;
      field_ev      = '0;
      status_valid  = 1'b0;
      status_kind   = clmd_pkg::EV_OK;
      do_key        = 1'b0;
      key_val       = '0;
      key_known_arg = 1'b0;
      key_known     = 1'b0;
      do_vdone      = 1'b0;
      vd_val        = '0;
      do_finish     = 1'b0;
      do_check      = 1'b0;
      chk_empty     = 1'b0;

      if (accept) begin
         if (req_bus.data.first_byte) begin
            // Start a new message: drop whatever was in progress
            entries_in  = '0;
            arg_left_in = '0;
            accum_in    = '0;
            key_in      = '0;
            known_in    = 1'b0;
            str_left_in = '0;
            is_text_in  = 1'b0;
            bytes_in    = msg_len;
            if ((msg_len == '0) || (major != clmd_pkg::MAJOR_MAP)) begin
               status_valid = 1'b1;
               status_kind  = clmd_pkg::EV_FAIL;
               phase_in     = clmd_pkg::PH_IDLE;
            end else begin
               bytes_in = bl;
               if (hdr_go) begin
                  phase_in    = clmd_pkg::PH_MAP_ARG;
                  arg_left_in = need;
               end else begin
                  entries_in = hdr_val;
                  accum_in   = hdr_val;
                  do_check   = 1'b1;
                  chk_empty  = (hdr_val == '0);
               end
            end
         end else if (phase_ff != clmd_pkg::PH_IDLE) begin
            if (bytes_ff == '0) begin
               phase_in = clmd_pkg::PH_IDLE;
            end else begin
               bytes_in = bl;
               unique case (phase_ff)
                  clmd_pkg::PH_MAP_ARG, clmd_pkg::PH_KEY_ARG, clmd_pkg::PH_VAL_ARG: begin
                     // Collect one argument byte, big endian
                     accum_in    = shifted;
                     arg_left_in = arg_next;
                     if (arg_next == 4'd0) begin
                        if (phase_ff == clmd_pkg::PH_MAP_ARG) begin
                           entries_in = shifted;
                           do_check   = 1'b1;
                           chk_empty  = (shifted == '0);
                        end else if (phase_ff == clmd_pkg::PH_KEY_ARG) begin
                           do_key        = 1'b1;
                           key_val       = shifted;
                           key_known_arg = known_ff;
                        end else begin
                           do_vdone = 1'b1;
                           vd_val   = shifted;
                        end
                     end
                  end
                  clmd_pkg::PH_KEY_HDR: begin
                     if ((major != clmd_pkg::MAJOR_UINT) && (major != clmd_pkg::MAJOR_NINT)) begin
                        status_valid = 1'b1;
                        status_kind  = clmd_pkg::EV_FAIL;
                        phase_in     = clmd_pkg::PH_IDLE;
                     end else begin
                        known_in = (major == clmd_pkg::MAJOR_UINT);
                        if (hdr_go) begin
                           phase_in    = clmd_pkg::PH_KEY_ARG;
                           accum_in    = '0;
                           arg_left_in = need;
                        end else begin
                           accum_in      = hdr_val;
                           do_key        = 1'b1;
                           key_val       = hdr_val;
                           key_known_arg = (major == clmd_pkg::MAJOR_UINT);
                        end
                     end
                  end
                  clmd_pkg::PH_VAL_HDR: begin
                     if ((val_cls == clmd_pkg::CL_NUM) ||
                         ((val_cls == clmd_pkg::CL_TEXT) && (major == clmd_pkg::MAJOR_TEXT)) ||
                         ((val_cls == clmd_pkg::CL_OCTET) && (major == clmd_pkg::MAJOR_BYTES))) begin
                        if (val_cls != clmd_pkg::CL_NUM) begin
                           is_text_in = (val_cls == clmd_pkg::CL_TEXT);
                        end
                        if (hdr_go) begin
                           phase_in    = clmd_pkg::PH_VAL_ARG;
                           accum_in    = '0;
                           arg_left_in = need;
                        end else begin
                           accum_in = hdr_val;
                           do_vdone = 1'b1;
                           vd_val   = hdr_val;
                        end
                     end else if (val_cls == clmd_pkg::CL_FLAG) begin
                        field_valid           = 1'b1;
                        field_ev.event_kind   = clmd_pkg::EV_FLAG;
                        field_ev.field_key    = key_ff;
                        field_ev.field_value  = {63'd0, cur_byte == clmd_pkg::SIMPLE_TRUE};
                        field_ev.end_of_field = 1'b1;
                        do_finish             = 1'b1;
                     end else begin
                        do_finish = 1'b1;
                     end
                  end
                  clmd_pkg::PH_STR: begin
                     // Pass one string byte through
                     str_left_in           = str_next;
                     field_valid           = 1'b1;
                     field_ev.event_kind   = is_text_ff ? clmd_pkg::EV_TEXT : clmd_pkg::EV_OCTET;
                     field_ev.field_key    = key_ff;
                     field_ev.field_value  = {56'd0, cur_byte};
                     field_ev.end_of_field = (str_next == '0);
                     do_finish             = (str_next == '0);
                  end
                  default: begin
                     phase_in = clmd_pkg::PH_IDLE;
                  end
               endcase
            end
         end
      end

      // Key complete: keep it only if it names a known field
      if (do_key) begin
         key_known = key_known_arg && (clmd_pkg::key_class(key_val) != clmd_pkg::CL_NONE);
         known_in  = key_known;
         key_in    = key_known ? key_val[4:0] : 5'd0;
         if (bl == '0) begin
            status_valid = 1'b1;
            status_kind  = clmd_pkg::EV_FAIL;
            phase_in     = clmd_pkg::PH_IDLE;
         end else begin
            phase_in = clmd_pkg::PH_VAL_HDR;
         end
      end

      // Value argument complete: emit a number or an empty event, open a string, or skip an overlong one
      if (do_vdone) begin
         if (clmd_pkg::key_class({59'd0, key_ff}) == clmd_pkg::CL_NUM) begin
            field_valid           = 1'b1;
            field_ev.event_kind   = clmd_pkg::EV_NUM;
            field_ev.field_key    = key_ff;
            field_ev.field_value  = clmd_pkg::trunc_value(key_ff, vd_val);
            field_ev.end_of_field = 1'b1;
            do_finish             = 1'b1;
         end else if (vd_val > 64'(bl)) begin
            do_finish = 1'b1;
         end else if (vd_val == '0) begin
            field_valid           = 1'b1;
            field_ev.event_kind   = clmd_pkg::EV_EMPTY;
            field_ev.field_key    = key_ff;
            field_ev.field_value  = '0;
            field_ev.end_of_field = 1'b1;
            do_finish             = 1'b1;
         end else begin
            str_left_in = vd_val[LEN_BITS-1:0];
            phase_in    = clmd_pkg::PH_STR;
         end
      end

      // Entry complete: count it off
      if (do_finish) begin
         entries_in = entries_ff - 64'd1;
         do_check   = 1'b1;
         chk_empty  = (entries_ff == 64'd1);
      end

      // End of map when entries or bytes run out
      if (do_check) begin
         if (chk_empty || (bl == '0)) begin
            status_valid = 1'b1;
            status_kind  = clmd_pkg::EV_OK;
            phase_in     = clmd_pkg::PH_IDLE;
         end else begin
            phase_in = clmd_pkg::PH_KEY_HDR;
         end
      end
   end

   // Order the events: field first, status last
   always_comb begin
      status_ev              = '0;
      status_ev.event_kind   = status_kind;
      status_ev.end_of_field = 1'b1;
      push_data[0]           = field_valid ? field_ev : status_ev;
      push_data[1]           = status_ev;
      push_count             = 2'(field_valid) + 2'(status_valid);
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= clmd_pkg::PH_IDLE;
         entries_ff  <= '0;
         bytes_ff    <= '0;
         arg_left_ff <= '0;
         accum_ff    <= '0;
         key_ff      <= '0;
         known_ff    <= 1'b0;
         str_left_ff <= '0;
         is_text_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         entries_ff  <= entries_in;
         bytes_ff    <= bytes_in;
         arg_left_ff <= arg_left_in;
         accum_ff    <= accum_in;
         key_ff      <= key_in;
         known_ff    <= known_in;
         str_left_ff <= str_left_in;
         is_text_ff  <= is_text_in;
      end
   end

   clmd_event_queue u_event_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .has_room   (has_room),
      .rsp_bus    (rsp_bus)
   );

`ifndef SYNTH
   // A second event in one beat is always the success status
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (push_count == 2'd2) |-> (push_data[1].event_kind == clmd_pkg::EV_OK))
      else $error("two events in one beat without a closing status");

   // A status event ends the message
   a_status_idles: assert property (@(posedge clock) disable iff (reset)
      status_valid |=> (phase_ff == clmd_pkg::PH_IDLE))
      else $error("parser not idle after a status event");

   // Input stalls only behind a backlog of events
   a_stall_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("input stalled with an empty event queue");

   // Stray bytes while idle produce nothing
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_bus.data.first_byte && (phase_ff == clmd_pkg::PH_IDLE))
      |-> (push_count == 2'd0))
      else $error("event produced from a stray byte");
`endif

endmodule

FILE: sim/tb_cbor_lwm2m_map_decoder.sv
// Self-checking testbench for the CBOR LwM2M map decoder: directed and random byte
// streams, an in-bench event predictor and an in-order event checker.
// Depends on clmd_pkg, clmd_stream_if and cbor_lwm2m_map_decoder.
`timescale 1ns / 100ps

module tb_cbor_lwm2m_map_decoder;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned RANDOM_BYTES  = 1130;
   localparam int unsigned TAIL_BYTES    = 150;
   localparam int unsigned SETTLE_CYCLES = 20;

   typedef struct {
      clmd_pkg::req_payload_type beat;
      bit                        hold;
   } queued_byte_type;

   logic clock = 1'b0;
   logic reset;

   clmd_req_if req_bus ();
   clmd_rsp_if rsp_bus ();

   cbor_lwm2m_map_decoder #(.LEN_BITS(16)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // Stimulus and expectation stores
   queued_byte_type           bytes_to_send[$];
   clmd_pkg::rsp_payload_type events_due[$];
   logic [7:0]                msg_bytes[$];
   int unsigned               msg_beat_count = 0;
   int unsigned               mismatch_count = 0;
   int unsigned               cycle_count = 0;
   bit                        tail_quiet = 1'b0;

   // Decoder state as predicted
   clmd_pkg::phase_type dec_phase;
   logic [63:0]         dec_entries;
   logic [15:0]         dec_bytes;
   logic [3:0]          dec_arg_left;
   logic [63:0]         dec_accum;
   logic [4:0]          dec_key;
   logic                dec_key_known;
   logic [15:0]         dec_str_left;
   logic                dec_str_text;
   int unsigned         dec_events;

   // ---------------------------------------------------------------- store helpers

   function automatic void add_byte(input logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endfunction

   function automatic void add_beat(input queued_byte_type q);
      bytes_to_send.insert(bytes_to_send.size(), q);
   endfunction

   function automatic void add_due(input clmd_pkg::rsp_payload_type ev);
      events_due.insert(events_due.size(), ev);
   endfunction

   // ---------------------------------------------------------------- prediction

   function automatic clmd_pkg::key_class_type field_class(input logic [63:0] k);
      if (k > 64'd31) return clmd_pkg::CL_NONE;
      case (k[4:0])
         5'd0, 5'd1, 5'd3, 5'd5, 5'd11, 5'd20, 5'd21: return clmd_pkg::CL_NUM;
         5'd2, 5'd6, 5'd10, 5'd12, 5'd13:             return clmd_pkg::CL_TEXT;
         5'd4:                                        return clmd_pkg::CL_OCTET;
         5'd14:                                       return clmd_pkg::CL_FLAG;
         default:                                     return clmd_pkg::CL_NONE;
      endcase
   endfunction

   function automatic logic [63:0] field_mask(input logic [4:0] k, input logic [63:0] v);
      case (k)
         5'd0, 5'd5:   return v & 64'h0000_0000_0000_00ff;
         5'd3:         return v & 64'h0000_0000_0000_ffff;
         5'd11, 5'd20: return v & 64'h0000_0000_ffff_ffff;
         default:      return v;
      endcase
   endfunction

   // Queue one expected event; a byte gives at most two
   function automatic void post_event(input clmd_pkg::event_kind_type kind,
                                      input logic [4:0] key,
                                      input logic [63:0] value, input logic eof);
      clmd_pkg::rsp_payload_type ev;
      if (dec_events >= 2) return;
      ev.event_kind   = kind;
      ev.field_key    = key;
      ev.field_value  = value;
      ev.end_of_field = eof;
      add_due(ev);
      dec_events++;
   endfunction

   // Load an inline argument or arm the argument byte count; 1 if bytes follow
   function automatic bit open_arg(input logic [4:0] ai);
      logic [3:0] need;
      need = 4'd0;
      if (ai < clmd_pkg::AI_ONE_BYTE) begin
         dec_accum = {59'd0, ai};
         return 1'b0;
      end
      dec_accum = 64'd0;
      case (ai)
         clmd_pkg::AI_ONE_BYTE:   need = 4'd1;
         clmd_pkg::AI_TWO_BYTE:   need = 4'd2;
         clmd_pkg::AI_FOUR_BYTE:  need = 4'd4;
         clmd_pkg::AI_EIGHT_BYTE: need = 4'd8;
         default:                 need = 4'd0;
      endcase
      if (need == 4'd0 || dec_bytes < {12'd0, need}) return 1'b0;
      dec_arg_left = need;
      return 1'b1;
   endfunction

   function automatic void close_map_check();
      if (dec_entries == 64'd0 || dec_bytes == 16'd0) begin
         post_event(clmd_pkg::EV_OK, 5'd0, 64'd0, 1'b1);
         dec_phase = clmd_pkg::PH_IDLE;
      end else begin
         dec_phase = clmd_pkg::PH_KEY_HDR;
      end
   endfunction

   function automatic void close_entry();
      dec_entries = dec_entries - 64'd1;
      close_map_check();
   endfunction

   function automatic void close_key();
      bit known;
      known = dec_key_known && field_class(dec_accum) != clmd_pkg::CL_NONE;
      dec_key_known = known;
      dec_key = known ? dec_accum[4:0] : 5'd0;
      if (dec_bytes == 16'd0) begin
         post_event(clmd_pkg::EV_FAIL, 5'd0, 64'd0, 1'b1);
         dec_phase = clmd_pkg::PH_IDLE;
      end else begin
         dec_phase = clmd_pkg::PH_VAL_HDR;
      end
   endfunction

   function automatic void open_string(input logic [63:0] len);
      if (len > {48'd0, dec_bytes}) begin
         close_entry();
      end else if (len == 64'd0) begin
         post_event(clmd_pkg::EV_EMPTY, dec_key, 64'd0, 1'b1);
         close_entry();
      end else begin
         dec_str_left = len[15:0];
         dec_phase = clmd_pkg::PH_STR;
      end
   endfunction

   function automatic void close_value();
      if (field_class({59'd0, dec_key}) == clmd_pkg::CL_NUM) begin
         post_event(clmd_pkg::EV_NUM, dec_key, field_mask(dec_key, dec_accum), 1'b1);
         close_entry();
      end else begin
         open_string(dec_accum);
      end
   endfunction

   function automatic void decode_value_head(input logic [7:0] d);
      logic [7:0]              major;
      clmd_pkg::key_class_type cls;
      major = d & clmd_pkg::MAJOR_MASK;
      cls = dec_key_known ? field_class({59'd0, dec_key}) : clmd_pkg::CL_NONE;
      if (cls == clmd_pkg::CL_NUM) begin
         if (open_arg(d[4:0])) dec_phase = clmd_pkg::PH_VAL_ARG;
         else close_value();
      end else if ((cls == clmd_pkg::CL_TEXT && major == clmd_pkg::MAJOR_TEXT) ||
                   (cls == clmd_pkg::CL_OCTET && major == clmd_pkg::MAJOR_BYTES)) begin
         dec_str_text = (cls == clmd_pkg::CL_TEXT);
         if (open_arg(d[4:0])) dec_phase = clmd_pkg::PH_VAL_ARG;
         else close_value();
      end else if (cls == clmd_pkg::CL_FLAG) begin
         post_event(clmd_pkg::EV_FLAG, dec_key,
                    (d == clmd_pkg::SIMPLE_TRUE) ? 64'd1 : 64'd0, 1'b1);
         close_entry();
      end else begin
         close_entry();
      end
   endfunction

   // Advance the predicted decoder by one accepted beat
   function automatic void decode_byte(input clmd_pkg::req_payload_type b);
      logic [7:0] d;
      d = b.data_byte;
      dec_events = 0;
      if (b.first_byte) begin
         dec_phase     = clmd_pkg::PH_IDLE;
         dec_entries   = 64'd0;
         dec_arg_left  = 4'd0;
         dec_accum     = 64'd0;
         dec_key       = 5'd0;
         dec_key_known = 1'b0;
         dec_str_left  = 16'd0;
         dec_str_text  = 1'b0;
         dec_bytes     = b.msg_length;
         if (dec_bytes == 16'd0 || (d & clmd_pkg::MAJOR_MASK) != clmd_pkg::MAJOR_MAP) begin
            post_event(clmd_pkg::EV_FAIL, 5'd0, 64'd0, 1'b1);
            dec_phase = clmd_pkg::PH_IDLE;
            return;
         end
         dec_bytes = dec_bytes - 16'd1;
         if (open_arg(d[4:0])) begin
            dec_phase = clmd_pkg::PH_MAP_ARG;
         end else begin
            dec_entries = dec_accum;
            close_map_check();
         end
         return;
      end
      if (dec_phase == clmd_pkg::PH_IDLE) return;
      if (dec_bytes == 16'd0) begin
         dec_phase = clmd_pkg::PH_IDLE;
         return;
      end
      dec_bytes = dec_bytes - 16'd1;
      case (dec_phase)
         clmd_pkg::PH_MAP_ARG, clmd_pkg::PH_KEY_ARG, clmd_pkg::PH_VAL_ARG: begin
            dec_accum = {dec_accum[55:0], d};
            if (dec_arg_left > 4'd0) dec_arg_left = dec_arg_left - 4'd1;
            if (dec_arg_left == 4'd0) begin
               if (dec_phase == clmd_pkg::PH_MAP_ARG) begin
                  dec_entries = dec_accum;
                  close_map_check();
               end else if (dec_phase == clmd_pkg::PH_KEY_ARG) begin
                  close_key();
               end else begin
                  close_value();
               end
            end
         end
         clmd_pkg::PH_KEY_HDR: begin
            if ((d & clmd_pkg::MAJOR_MASK) != clmd_pkg::MAJOR_UINT &&
                (d & clmd_pkg::MAJOR_MASK) != clmd_pkg::MAJOR_NINT) begin
               post_event(clmd_pkg::EV_FAIL, 5'd0, 64'd0, 1'b1);
               dec_phase = clmd_pkg::PH_IDLE;
            end else begin
               dec_key_known = ((d & clmd_pkg::MAJOR_MASK) == clmd_pkg::MAJOR_UINT);
               if (open_arg(d[4:0])) dec_phase = clmd_pkg::PH_KEY_ARG;
               else close_key();
            end
         end
         clmd_pkg::PH_VAL_HDR: decode_value_head(d);
         default: begin
            if (dec_str_left > 16'd0) dec_str_left = dec_str_left - 16'd1;
            post_event(dec_str_text ? clmd_pkg::EV_TEXT : clmd_pkg::EV_OCTET, dec_key,
                       {56'd0, d}, dec_str_left == 16'd0);
            if (dec_str_left == 16'd0) close_entry();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Append a CBOR header, usually inline when small, sometimes wider than needed
   function automatic void add_head(input logic [7:0] major, input logic [63:0] v);
      int unsigned n;
      logic [4:0]  ai;
      if (v < 64'd24 && $urandom_range(0, 3) != 0) begin
         add_byte(major | v[7:0]);
         return;
      end
      if (v < 64'h100) n = 1;
      else if (v < 64'h1_0000) n = 2;
      else if (v < 64'h1_0000_0000) n = 4;
      else n = 8;
      if (n < 8 && $urandom_range(0, 5) == 0) n = n * 2;
      case (n)
         1:       ai = clmd_pkg::AI_ONE_BYTE;
         2:       ai = clmd_pkg::AI_TWO_BYTE;
         4:       ai = clmd_pkg::AI_FOUR_BYTE;
         default: ai = clmd_pkg::AI_EIGHT_BYTE;
      endcase
      add_byte(major | {3'b000, ai});
      for (int i = n - 1; i >= 0; i--) add_byte(v[8 * i +: 8]);
   endfunction

   function automatic logic [63:0] rand_number();
      case ($urandom_range(0, 5))
         0:       return 64'($urandom_range(0, 23));
         1:       return 64'($urandom_range(0, 255));
         2:       return 64'($urandom_range(0, 65535));
         3:       return {32'd0, $urandom};
         4:       return {$urandom, $urandom};
         default: return 64'hffff_ffff_ffff_ffff >> $urandom_range(0, 63);
      endcase
   endfunction

   // Append one key/value pair, mostly well formed
   function automatic void add_entry();
      logic [63:0]             k;
      logic [2:0]              mj;
      logic [4:0]              ai;
      clmd_pkg::key_class_type cls;
      int unsigned             r;
      int unsigned             n;
      int unsigned             declared;
      int unsigned             known_keys[14] = '{0, 1, 3, 5, 11, 20, 21, 2, 6, 10, 12, 13,
                                                  4, 14};
      r = $urandom_range(0, 99);
      if (r < 80) begin
         k = 64'(known_keys[$urandom_range(0, 13)]);
      end else if (r < 88) begin
         // unknown key, small or wide
         if ($urandom_range(0, 2) == 0) k = {$urandom, $urandom} | 64'h20;
         else begin
            k = 64'($urandom_range(0, 31));
            while (field_class(k) != clmd_pkg::CL_NONE) k = 64'($urandom_range(0, 31));
         end
      end else if (r < 95) begin
         add_head(clmd_pkg::MAJOR_NINT, 64'($urandom_range(0, 40)));
         add_byte(8'($urandom_range(0, 255)));
         return;
      end else begin
         // key of a bad major type
         mj = 3'($urandom_range(2, 7));
         ai = 5'($urandom);
         add_byte({mj, ai});
         return;
      end
      add_head(clmd_pkg::MAJOR_UINT, k);
      cls = field_class(k);
      case (cls)
         clmd_pkg::CL_NUM: begin
            if ($urandom_range(0, 9) == 0) begin
               mj = 3'($urandom_range(0, 7));
               if ($urandom_range(0, 1) == 0) begin
                  ai = 5'($urandom_range(28, 31));
                  add_byte({mj, ai});
               end else begin
                  add_head({mj, 5'd0}, rand_number());
               end
            end else begin
               add_head(clmd_pkg::MAJOR_UINT, rand_number());
            end
         end
         clmd_pkg::CL_TEXT, clmd_pkg::CL_OCTET: begin
            if ($urandom_range(0, 9) == 0) begin
               add_byte(8'($urandom_range(0, 255)));
            end else begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40) : $urandom_range(0, 6);
               declared = ($urandom_range(0, 14) == 0) ? n + $urandom_range(1, 300) : n;
               add_head((cls == clmd_pkg::CL_TEXT) ? clmd_pkg::MAJOR_TEXT
                                                   : clmd_pkg::MAJOR_BYTES,
                        64'(declared));
               repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
         end
         clmd_pkg::CL_FLAG: begin
            case ($urandom_range(0, 2))
               0:       add_byte(clmd_pkg::SIMPLE_TRUE);
               1:       add_byte(8'hf4);
               default: add_byte(8'($urandom_range(0, 255)));
            endcase
         end
         default: add_byte(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // Queue the first cut bytes of msg_bytes as one message of length len
   function automatic void send_msg(input int unsigned len, input int unsigned cut,
                                    input bit hold);
      queued_byte_type q;
      logic [15:0]     noise;
      for (int i = 0; i < cut; i++) begin
         noise = 16'($urandom);
         q.beat.data_byte  = msg_bytes[i];
         q.beat.first_byte = (i == 0);
         q.beat.msg_length = (i == 0) ? len[15:0] : noise;
         q.hold = hold && (i == 0);
         add_beat(q);
      end
      msg_beat_count += cut;
   endfunction

   function automatic void send_stray();
      queued_byte_type q;
      q.beat.data_byte  = 8'($urandom);
      q.beat.first_byte = 1'b0;
      q.beat.msg_length = 16'($urandom);
      q.hold = 1'b0;
      add_beat(q);
   endfunction

   function automatic void send_random_msg();
      int unsigned entries;
      int unsigned count;
      int unsigned len;
      int unsigned cut;
      int unsigned r;
      msg_bytes.delete();
      entries = $urandom_range(1, 6);
      r = $urandom_range(0, 9);
      if (r == 0) count = entries + $urandom_range(1, 3);
      else if (r == 1) count = $urandom_range(0, entries - 1);
      else count = entries;
      add_head(clmd_pkg::MAJOR_MAP, 64'(count));
      repeat (entries) add_entry();
      len = msg_bytes.size();
      r = $urandom_range(0, 9);
      if (r == 0) len = $urandom_range(1, len);
      else if (r == 1) len = $urandom_range(len, 65535);
      cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, msg_bytes.size())
                                         : msg_bytes.size();
      send_msg(len, cut, $urandom_range(0, 29) == 0);
   endfunction

   // ---------------------------------------------------------------- byte driver

   int unsigned gap_left;
   int unsigned calm_left;

   always @(posedge clock) begin : drive
      queued_byte_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
         calm_left = 0;
      end else begin
         // predict the beat that just went in
         if (req_bus.valid && req_bus.ready) decode_byte(req_bus.data);
         tail_quiet = (bytes_to_send.size() < TAIL_BYTES);
         // hold a stalled beat, otherwise idle or present the next one
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (bytes_to_send.size() == 0 ||
                         (bytes_to_send[0].hold && events_due.size() != 0)) begin
               req_bus.valid <= 1'b0;
            end else if (!tail_quiet && calm_left == 0 && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(1, 11) - 1;
               req_bus.valid <= 1'b0;
               if ($urandom_range(0, 2) == 0) calm_left = $urandom_range(20, 80);
            end else begin
               if (calm_left > 0) calm_left--;
               nxt = bytes_to_send.pop_front();
               req_bus.data  <= nxt.beat;
               req_bus.valid <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- event monitor

   int unsigned stall_left;
   int unsigned steady_left;

   always @(posedge clock) begin : observe
      clmd_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         steady_left = 0;
      end else begin
         // compare each accepted event with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (events_due.size() == 0) begin
               $error("unexpected event: kind %0d key %0d value %0h end %0b",
                      rsp_bus.data.event_kind, rsp_bus.data.field_key,
                      rsp_bus.data.field_value, rsp_bus.data.end_of_field);
               mismatch_count++;
            end else begin
               want = events_due.pop_front();
               if (rsp_bus.data.event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, actual %0d",
                         want.event_kind, rsp_bus.data.event_kind);
                  mismatch_count++;
               end
               if (rsp_bus.data.field_key !== want.field_key) begin
                  $error("field_key: expected %0d, actual %0d",
                         want.field_key, rsp_bus.data.field_key);
                  mismatch_count++;
               end
               if (rsp_bus.data.field_value !== want.field_value) begin
                  $error("field_value: expected %0h, actual %0h",
                         want.field_value, rsp_bus.data.field_value);
                  mismatch_count++;
               end
               if (rsp_bus.data.end_of_field !== want.end_of_field) begin
                  $error("end_of_field: expected %0b, actual %0b",
                         want.end_of_field, rsp_bus.data.end_of_field);
                  mismatch_count++;
               end
            end
         end
         // stall in random bursts, none near the end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!tail_quiet && steady_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_bus.ready <= 1'b0;
            if ($urandom_range(0, 2) == 0) steady_left = $urandom_range(20, 80);
         end else begin
            if (steady_left > 0) steady_left--;
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- run control

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;

      // stray byte while idle
      send_stray();
      // zero length fails
      msg_bytes = '{8'ha1};
      send_msg(0, 1, 1'b0);
      // first byte that is not a map fails
      msg_bytes = '{8'h00};
      send_msg(5, 1, 1'b0);
      // header that takes every byte, then an empty map
      msg_bytes = '{8'ha5};
      send_msg(1, 1, 1'b0);
      msg_bytes = '{8'ha0};
      send_msg(4, 1, 1'b0);
      // flag, empty text, one octet, negative key; longest length
      msg_bytes = '{8'ha4, 8'h0e, 8'hf5, 8'h02, 8'h60, 8'h04, 8'h41, 8'h80, 8'h21, 8'h00};
      send_msg(65535, 10, 1'b0);
      // message abandoned by an early restart
      msg_bytes = '{8'ha1, 8'h03, 8'h19, 8'h12, 8'h34};
      send_msg(5, 2, 1'b0);
      // truncated response code from a full 8-byte argument, then a bad key;
      // wait for every event before this message goes in
      msg_bytes = '{8'ha3, 8'h05, 8'h1b, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'h40};
      send_msg(12, 12, 1'b1);
      // argument too short for its header, then a key on the last byte
      msg_bytes = '{8'ha2, 8'h0b, 8'h1a, 8'h00};
      send_msg(4, 4, 1'b0);

      // random messages with some noise between them
      while (msg_beat_count < RANDOM_BYTES) begin
         if ($urandom_range(0, 24) == 0) repeat ($urandom_range(1, 3)) send_stray();
         else send_random_msg();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain, then let the block settle
      while (bytes_to_send.size() != 0 || req_bus.valid || events_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/clmd_pkg.sv
design/clmd_stream_if.sv
design/clmd_event_queue.sv
design/cbor_lwm2m_map_decoder.sv
sim/tb_cbor_lwm2m_map_decoder.sv
